FILE: sv/assert_macros.svh
// ============================================================================
// Assertion macros
// Clocked implication checks shared by the frame slot ring manager. Each
// check samples on the rising edge of clk and stands down while rst_n is low.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMP(lbl, ante, cons, msg)
`define ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

FILE: sv/fsrm_pkg.sv
// ============================================================================
// fsrm_pkg
// Types, field widths and codes shared by the frame slot ring manager.
// ============================================================================
`timescale 1ns / 1ps

package fsrm_pkg;

    // Field and counter widths
    localparam int unsigned TIME_W       = 48;
    localparam int unsigned CNT32_W      = 32;
    localparam int unsigned MODE_W       = 2;
    localparam int unsigned SLOT_COUNT_W = 4;
    localparam int unsigned HANDLE_W     = 3;
    localparam int unsigned ACTION_W     = 3;
    localparam int unsigned STATUS_W     = 2;
    localparam int unsigned QUEUED_W     = 4;
    localparam int unsigned CFG_INDEX_W  = 1;
    localparam int unsigned CFG_DATA_W   = 4;
    localparam int unsigned DIV_CNT_W    = $clog2(TIME_W);
    localparam int unsigned MIN_SLOTS    = 2;
    localparam int unsigned RESET_SLOTS  = 8;

    // Actions
    localparam logic [ACTION_W-1:0] ACT_ACQ_WRITE = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_SUBMIT    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_ACQ_READ  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_RELEASE   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_TICK      = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_QUERY     = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_CLEAR     = 3'd6;

    // Result status
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

    // Slot modes
    localparam logic [MODE_W-1:0] MODE_FREE      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITING   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READY     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RENDERING = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HALTED     = 1'b1;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [HANDLE_W-1:0] slot_handle;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] granted_slot;
        logic [QUEUED_W-1:0] queued_frames;
        logic [CNT32_W-1:0]  dropped_frames;
        logic [TIME_W-1:0]   average_latency;
    } result_t;

    // Datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NOP,
        OP_SEL_WP,
        OP_SEL_RP,
        OP_SEL_HANDLE,
        OP_MOD_STEP,
        OP_READ,
        OP_ADVANCE,
        OP_CLAIM,
        OP_DROP,
        OP_REFUSE,
        OP_SUBMIT,
        OP_TAKE,
        OP_LATENCY,
        OP_RELEASE,
        OP_TICK,
        OP_OK,
        OP_CLEAR,
        OP_DIV_INIT,
        OP_DIV_STEP
    } dp_op_t;

    typedef struct packed {
        logic   load;
        logic   emit;
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                halted;
        logic                handle_ok;
        logic                idx_ge_n;
        logic                scan_last;
        logic [MODE_W-1:0]   mode;
        logic                rendered_zero;
        logic                div_last;
        logic                out_free;
    } sts_t;

endpackage

FILE: sv/fsrm_ram.sv
// ============================================================================
// fsrm_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`timescale 1ns / 1ps

module fsrm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; read data holds between reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/fsrm_datapath.sv
// ============================================================================
// fsrm_datapath
// Slot store, pointers, counters, latency totals, serial divider, config
// registers and the result register of the frame slot ring manager.
// ============================================================================
`timescale 1ns / 1ps

module fsrm_datapath #(
    parameter int unsigned MAX_SLOTS = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [fsrm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [fsrm_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  fsrm_pkg::item_t                       item,
    output fsrm_pkg::result_t                     result,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    input  fsrm_pkg::cmd_t                        cmd,
    output fsrm_pkg::sts_t                        sts
);

    localparam int unsigned PTR_W   = $clog2(MAX_SLOTS);
    localparam int unsigned CNT_W   = $clog2(MAX_SLOTS + 1);
    localparam int unsigned TIME_W  = fsrm_pkg::TIME_W;
    localparam int unsigned C32_W   = fsrm_pkg::CNT32_W;
    localparam int unsigned MODE_W  = fsrm_pkg::MODE_W;
    localparam int unsigned RAM_W   = MODE_W + TIME_W;
    localparam int unsigned GRANT_W = fsrm_pkg::HANDLE_W;
    localparam int unsigned QUEUE_W = fsrm_pkg::QUEUED_W;
    localparam int unsigned DCNT_W  = fsrm_pkg::DIV_CNT_W;
    localparam int unsigned SC_W    = fsrm_pkg::SLOT_COUNT_W;

    // Control state (reset)
    logic [SC_W-1:0]      slot_count_reg, slot_count_next;
    logic                 halted_reg, halted_next;
    logic [MAX_SLOTS-1:0] valid_reg, valid_next;
    logic [PTR_W-1:0]     wp_reg, wp_next;
    logic [PTR_W-1:0]     rp_reg, rp_next;
    logic [CNT_W-1:0]     waiting_reg, waiting_next;
    logic [C32_W-1:0]     drop_reg, drop_next;
    logic [C32_W-1:0]     rendered_reg, rendered_next;
    logic [TIME_W-1:0]    lat_sum_reg, lat_sum_next;
    logic [TIME_W-1:0]    time_reg, time_next;
    logic                 result_valid_reg, result_valid_next;

    // Working and payload registers (no reset)
    fsrm_pkg::item_t                 item_reg, item_next;
    logic [PTR_W-1:0]                idx_reg, idx_next;
    logic [CNT_W-1:0]                scan_reg, scan_next;
    logic                            vld_rd_reg, vld_rd_next;
    logic [TIME_W-1:0]               lat_reg, lat_next;
    logic [C32_W-1:0]                rem_reg, rem_next;
    logic [TIME_W-1:0]               avg_reg, avg_next;
    logic [DCNT_W-1:0]               div_cnt_reg, div_cnt_next;
    logic [fsrm_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [PTR_W-1:0]                granted_reg, granted_next;
    fsrm_pkg::result_t               result_reg, result_next;

    // Slot store port
    logic               ram_we;
    logic               ram_re;
    logic [MODE_W-1:0]  ram_wmode;
    logic [RAM_W-1:0]   ram_rdata;

    // Derived values
    logic [CNT_W-1:0]   ring_n;
    logic [CNT_W-1:0]   idx_ext;
    logic [CNT_W-1:0]   idx_inc;
    logic [PTR_W-1:0]   idx_wrap;
    logic [MODE_W-1:0]  rd_mode;
    logic [TIME_W-1:0]  rd_stamp;
    logic [TIME_W:0]    sum_ext;
    logic [C32_W:0]     trial;
    logic               trial_ge;
    logic               out_free;

    fsrm_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata ({ram_wmode, (ram_wmode == fsrm_pkg::MODE_WRITING) ? time_reg : rd_stamp}),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // Clamp the slot count into the ring's legal range
    always_comb
    begin
        if (32'(slot_count_reg) < fsrm_pkg::MIN_SLOTS)
        begin
            ring_n = CNT_W'(fsrm_pkg::MIN_SLOTS);
        end
        else if (32'(slot_count_reg) > MAX_SLOTS)
        begin
            ring_n = CNT_W'(MAX_SLOTS);
        end
        else
        begin
            ring_n = CNT_W'(slot_count_reg);
        end
    end

    // Slot index helpers; a never-written slot reads as free
    assign idx_ext  = CNT_W'(idx_reg);
    assign idx_inc  = idx_ext + CNT_W'(1);
    assign idx_wrap = (idx_inc == ring_n) ? '0 : PTR_W'(idx_inc);
    assign rd_mode  = vld_rd_reg ? ram_rdata[RAM_W-1 -: MODE_W] : fsrm_pkg::MODE_FREE;
    assign rd_stamp = ram_rdata[TIME_W-1:0];

    // Saturating latency accumulate and one restoring divider step
    assign sum_ext  = {1'b0, lat_sum_reg} + {1'b0, lat_reg};
    assign trial    = {rem_reg, avg_reg[TIME_W-1]};
    assign trial_ge = trial >= {1'b0, rendered_reg};

    assign out_free = !result_valid_reg || !result_stall;

    // Next-state logic for every register
    always_comb
    begin
        slot_count_next   = slot_count_reg;
        halted_next       = halted_reg;
        valid_next        = valid_reg;
        wp_next           = wp_reg;
        rp_next           = rp_reg;
        waiting_next      = waiting_reg;
        drop_next         = drop_reg;
        rendered_next     = rendered_reg;
        lat_sum_next      = lat_sum_reg;
        time_next         = time_reg;
        result_valid_next = result_valid_reg;
        item_next         = item_reg;
        idx_next          = idx_reg;
        scan_next         = scan_reg;
        vld_rd_next       = vld_rd_reg;
        lat_next          = lat_reg;
        rem_next          = rem_reg;
        avg_next          = avg_reg;
        div_cnt_next      = div_cnt_reg;
        status_next       = status_reg;
        granted_next      = granted_reg;
        result_next       = result_reg;
        ram_we            = 1'b0;
        ram_re            = 1'b0;
        ram_wmode         = fsrm_pkg::MODE_FREE;

        // Take configuration writes
        if (cfg_write)
        begin
            case (cfg_index)
                fsrm_pkg::CFG_SLOT_COUNT: slot_count_next = cfg_data;
                fsrm_pkg::CFG_HALTED:     halted_next     = cfg_data[0];
                default: ;
            endcase
        end

        // Latch a new word and clear the result fields
        if (cmd.load)
        begin
            item_next    = item;
            status_next  = fsrm_pkg::ST_IGNORED;
            granted_next = '0;
            avg_next     = '0;
        end

        case (cmd.op)
            fsrm_pkg::OP_SEL_WP:
            begin
                idx_next  = wp_reg;
                scan_next = '0;
            end
            fsrm_pkg::OP_SEL_RP:
            begin
                idx_next = rp_reg;
            end
            fsrm_pkg::OP_SEL_HANDLE:
            begin
                idx_next = PTR_W'(item_reg.slot_handle);
            end
            fsrm_pkg::OP_MOD_STEP:
            begin
                idx_next = PTR_W'(idx_ext - ring_n);
            end
            fsrm_pkg::OP_READ:
            begin
                ram_re      = 1'b1;
                vld_rd_next = valid_reg[idx_reg];
            end
            fsrm_pkg::OP_ADVANCE:
            begin
                idx_next  = idx_wrap;
                scan_next = scan_reg + CNT_W'(1);
            end
            fsrm_pkg::OP_CLAIM:
            begin
                ram_we       = 1'b1;
                ram_wmode    = fsrm_pkg::MODE_WRITING;
                granted_next = idx_reg;
                status_next  = fsrm_pkg::ST_OK;
            end
            fsrm_pkg::OP_DROP:
            begin
                if (drop_reg != '1)
                begin
                    drop_next = drop_reg + C32_W'(1);
                end
                status_next = fsrm_pkg::ST_REFUSED;
            end
            fsrm_pkg::OP_REFUSE:
            begin
                status_next = fsrm_pkg::ST_REFUSED;
            end
            fsrm_pkg::OP_SUBMIT:
            begin
                ram_we       = 1'b1;
                ram_wmode    = fsrm_pkg::MODE_READY;
                waiting_next = waiting_reg + CNT_W'(1);
                wp_next      = idx_wrap;
                status_next  = fsrm_pkg::ST_OK;
            end
            fsrm_pkg::OP_TAKE:
            begin
                ram_we    = 1'b1;
                ram_wmode = fsrm_pkg::MODE_RENDERING;
                if (waiting_reg != '0)
                begin
                    waiting_next = waiting_reg - CNT_W'(1);
                end
                granted_next = idx_reg;
                status_next  = fsrm_pkg::ST_OK;
            end
            fsrm_pkg::OP_LATENCY:
            begin
                lat_next = time_reg - rd_stamp;
            end
            fsrm_pkg::OP_RELEASE:
            begin
                ram_we       = 1'b1;
                ram_wmode    = fsrm_pkg::MODE_FREE;
                lat_sum_next = sum_ext[TIME_W] ? '1 : sum_ext[TIME_W-1:0];
                if (rendered_reg != '1)
                begin
                    rendered_next = rendered_reg + C32_W'(1);
                end
                rp_next     = idx_wrap;
                status_next = fsrm_pkg::ST_OK;
            end
            fsrm_pkg::OP_TICK:
            begin
                time_next   = time_reg + TIME_W'(1);
                status_next = fsrm_pkg::ST_OK;
            end
            fsrm_pkg::OP_OK:
            begin
                status_next = fsrm_pkg::ST_OK;
            end
            fsrm_pkg::OP_CLEAR:
            begin
                drop_next     = '0;
                rendered_next = '0;
                lat_sum_next  = '0;
                time_next     = '0;
                status_next   = fsrm_pkg::ST_OK;
            end
            fsrm_pkg::OP_DIV_INIT:
            begin
                rem_next     = '0;
                avg_next     = lat_sum_reg;
                div_cnt_next = '0;
                status_next  = fsrm_pkg::ST_OK;
            end
            fsrm_pkg::OP_DIV_STEP:
            begin
                rem_next     = trial_ge ? C32_W'(trial - {1'b0, rendered_reg})
                                        : trial[C32_W-1:0];
                avg_next     = {avg_reg[TIME_W-2:0], trial_ge};
                div_cnt_next = div_cnt_reg + DCNT_W'(1);
            end
            default: ;
        endcase

        // Any store write makes the entry valid
        if (ram_we)
        begin
            valid_next[idx_reg] = 1'b1;
        end

        // Load the result register, or drop the word once taken
        if (cmd.emit)
        begin
            result_valid_next           = 1'b1;
            result_next.status          = status_reg;
            result_next.granted_slot    = GRANT_W'(granted_reg);
            result_next.queued_frames   = QUEUE_W'(waiting_reg);
            result_next.dropped_frames  = drop_reg;
            result_next.average_latency = avg_reg;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg   <= SC_W'(fsrm_pkg::RESET_SLOTS);
            halted_reg       <= 1'b0;
            valid_reg        <= '0;
            wp_reg           <= '0;
            rp_reg           <= '0;
            waiting_reg      <= '0;
            drop_reg         <= '0;
            rendered_reg     <= '0;
            lat_sum_reg      <= '0;
            time_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            slot_count_reg   <= slot_count_next;
            halted_reg       <= halted_next;
            valid_reg        <= valid_next;
            wp_reg           <= wp_next;
            rp_reg           <= rp_next;
            waiting_reg      <= waiting_next;
            drop_reg         <= drop_next;
            rendered_reg     <= rendered_next;
            lat_sum_reg      <= lat_sum_next;
            time_reg         <= time_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        idx_reg     <= idx_next;
        scan_reg    <= scan_next;
        vld_rd_reg  <= vld_rd_next;
        lat_reg     <= lat_next;
        rem_reg     <= rem_next;
        avg_reg     <= avg_next;
        div_cnt_reg <= div_cnt_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
        result_reg  <= result_next;
    end

    // Status towards the controller
    always_comb
    begin
        sts.action        = item_reg.action;
        sts.halted        = halted_reg;
        sts.handle_ok     = 32'(item_reg.slot_handle) < 32'(ring_n);
        sts.idx_ge_n      = idx_ext >= ring_n;
        sts.scan_last     = (scan_reg + CNT_W'(1)) == ring_n;
        sts.mode          = rd_mode;
        sts.rendered_zero = rendered_reg == '0;
        sts.div_last      = div_cnt_reg == DCNT_W'(TIME_W - 1);
        sts.out_free      = out_free;
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

FILE: sv/fsrm_ctrl.sv
// ============================================================================
// fsrm_ctrl
// Sequencer of the frame slot ring manager: takes one word at a time, steps
// the datapath through pointer reduction, slot scan, slot update or division,
// and hands the result to the output register.
// ============================================================================
`timescale 1ns / 1ps

module fsrm_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  fsrm_pkg::sts_t  sts,
    output fsrm_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MOD,
        S_CHECK,
        S_RELEASE,
        S_DIVIDE,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   stall_reg;

    // Sequence one word
    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.emit   = 1'b0;
        cmd.op     = fsrm_pkg::OP_NOP;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid && !stall_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                state_next = S_FINISH;
                case (sts.action)
                    fsrm_pkg::ACT_ACQ_WRITE:
                    begin
                        if (sts.halted)
                        begin
                            cmd.op = fsrm_pkg::OP_REFUSE;
                        end
                        else
                        begin
                            cmd.op     = fsrm_pkg::OP_SEL_WP;
                            state_next = S_MOD;
                        end
                    end
                    fsrm_pkg::ACT_ACQ_READ:
                    begin
                        if (sts.halted)
                        begin
                            cmd.op = fsrm_pkg::OP_REFUSE;
                        end
                        else
                        begin
                            cmd.op     = fsrm_pkg::OP_SEL_RP;
                            state_next = S_MOD;
                        end
                    end
                    fsrm_pkg::ACT_SUBMIT,
                    fsrm_pkg::ACT_RELEASE:
                    begin
                        if (sts.handle_ok)
                        begin
                            cmd.op     = fsrm_pkg::OP_SEL_HANDLE;
                            state_next = S_MOD;
                        end
                    end
                    fsrm_pkg::ACT_TICK:
                    begin
                        cmd.op = fsrm_pkg::OP_TICK;
                    end
                    fsrm_pkg::ACT_QUERY:
                    begin
                        if (sts.rendered_zero)
                        begin
                            cmd.op = fsrm_pkg::OP_OK;
                        end
                        else
                        begin
                            cmd.op     = fsrm_pkg::OP_DIV_INIT;
                            state_next = S_DIVIDE;
                        end
                    end
                    fsrm_pkg::ACT_CLEAR:
                    begin
                        cmd.op = fsrm_pkg::OP_CLEAR;
                    end
                    default: ;
                endcase
            end

            // Bring the slot index into the ring, then read the slot
            S_MOD:
            begin
                if (sts.idx_ge_n)
                begin
                    cmd.op = fsrm_pkg::OP_MOD_STEP;
                end
                else
                begin
                    cmd.op     = fsrm_pkg::OP_READ;
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                state_next = S_FINISH;
                case (sts.action)
                    fsrm_pkg::ACT_ACQ_WRITE:
                    begin
                        if (sts.mode == fsrm_pkg::MODE_FREE)
                        begin
                            cmd.op = fsrm_pkg::OP_CLAIM;
                        end
                        else if (sts.scan_last)
                        begin
                            cmd.op = fsrm_pkg::OP_DROP;
                        end
                        else
                        begin
                            cmd.op     = fsrm_pkg::OP_ADVANCE;
                            state_next = S_MOD;
                        end
                    end
                    fsrm_pkg::ACT_SUBMIT:
                    begin
                        if (sts.mode == fsrm_pkg::MODE_WRITING)
                        begin
                            cmd.op = fsrm_pkg::OP_SUBMIT;
                        end
                    end
                    fsrm_pkg::ACT_ACQ_READ:
                    begin
                        if (sts.mode == fsrm_pkg::MODE_READY)
                        begin
                            cmd.op = fsrm_pkg::OP_TAKE;
                        end
                        else
                        begin
                            cmd.op = fsrm_pkg::OP_REFUSE;
                        end
                    end
                    fsrm_pkg::ACT_RELEASE:
                    begin
                        if (sts.mode == fsrm_pkg::MODE_RENDERING)
                        begin
                            cmd.op     = fsrm_pkg::OP_LATENCY;
                            state_next = S_RELEASE;
                        end
                    end
                    default: ;
                endcase
            end

            S_RELEASE:
            begin
                cmd.op     = fsrm_pkg::OP_RELEASE;
                state_next = S_FINISH;
            end

            // One quotient bit per cycle
            S_DIVIDE:
            begin
                cmd.op = fsrm_pkg::OP_DIV_STEP;
                if (sts.div_last)
                begin
                    state_next = S_FINISH;
                end
            end

            // Hold until the output register can take the word
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= (state_next != S_IDLE);
        end
    end

    assign item_stall = stall_reg;

endmodule

FILE: sv/frame_slot_ring_manager.sv
// ============================================================================
// frame_slot_ring_manager
// Frame slot ring manager. Handles one command word at a time and returns
// exactly one result word for each. Tick and stats reset go from decode
// straight to the result; submit, acquire-read and release check one slot,
// and release then computes the frame latency before freeing the slot. A
// stale pointer is first reduced by the ring length, one step per ring
// length, until it lies in the ring after the slot count shrinks. An
// acquire-write reads the slot store once per slot examined, through its
// registered read port, and examines at most the clamped slot count. A stats
// query with frames rendered runs the serial divider, one quotient bit per
// cycle. A new command is taken while the previous result still waits in the
// output register. No clearing pass is needed after reset.
// ============================================================================
`timescale 1ns / 1ps

`include "assert_macros.svh"

module frame_slot_ring_manager #(
    parameter int unsigned MAX_SLOTS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [fsrm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fsrm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  fsrm_pkg::item_t                   item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output fsrm_pkg::result_t                 result
);

    fsrm_pkg::cmd_t cmd;
    fsrm_pkg::sts_t sts;

    fsrm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    fsrm_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .sts          (sts)
    );

    // Busy straight after taking a word
    `ASSERT_NXT(a_stall_after_accept, item_valid && !item_stall, item_stall, "no stall after accept")

    // Going idle always leaves a result in the output register
    `ASSERT_IMP(a_idle_has_result, $fell(item_stall), result_valid, "idle without result")

    // Only a granted acquire reports a slot
    `ASSERT_IMP(a_grant_only_ok, result_valid && (result.status != fsrm_pkg::ST_OK), result.granted_slot == '0, "slot on failed command")

    // A nonzero average only comes with a successful query
    `ASSERT_IMP(a_avg_only_ok, result_valid && (result.average_latency != '0), result.status == fsrm_pkg::ST_OK, "average on failed command")

endmodule
